/* hdl/lnr_pkg.sv */
// Types, constants and the entry table of the noise resonator.
package lnr_pkg;

    localparam int          Y_W        = 48;    // filter history width
    localparam int          ACC_W      = 56;    // working width of the filter sum
    localparam int          NOISE_W    = 13;    // noise sample width
    localparam int          COEF_W     = 16;    // Q15 coefficient
    localparam int          COEF_FRAC  = 15;
    localparam int          IDX_W      = 7;
    localparam int          SHIFT_W    = 4;
    localparam int          SAMPLE_W   = 8;

    localparam logic [15:0] LFSR_SEED  = 16'd205;
    localparam logic [15:0] LFSR_TAPS  = 16'h002D;

    localparam logic [SHIFT_W-1:0] SHIFT_DEFAULT = 4'd8;

    // Beat kinds on the input channel
    localparam logic KIND_RESTART = 1'b0;
    localparam logic KIND_SAMPLE  = 1'b1;

    // Coefficients used by the table
    localparam logic [COEF_W-1:0] COEF_A = 16'h930C;
    localparam logic [COEF_W-1:0] COEF_B = 16'hCF74;
    localparam logic [COEF_W-1:0] COEF_C = 16'h0002;
    localparam logic [COEF_W-1:0] COEF_D = 16'h308C;
    localparam logic [COEF_W-1:0] COEF_E = 16'h0B8B;
    localparam logic [COEF_W-1:0] COEF_F = 16'h502E;
    localparam logic [COEF_W-1:0] COEF_G = 16'h66F0;

    typedef struct packed {
        logic                 valid;
        logic [COEF_W-1:0]    coef;
        logic                 light;
        logic [SHIFT_W-1:0]   shift;
    } t_entry;

    localparam t_entry ENTRY_SILENT = '{valid: 1'b0, coef: '0, light: 1'b0,
                                        shift: SHIFT_DEFAULT};

    function automatic t_entry mk(input logic [COEF_W-1:0] c, input logic l,
                                  input logic [SHIFT_W-1:0] s);
        t_entry e;
        e.valid = 1'b1;
        e.coef  = c;
        e.light = l;
        e.shift = s;
        return e;
    endfunction

    // Built-in entry table; anything not listed is silent.
    function automatic t_entry entry_lookup(input logic [IDX_W-1:0] idx);
        t_entry e;
        e = ENTRY_SILENT;
        case (idx)
            7'd8:    e = mk(COEF_A, 1'b0, 4'd8);
            7'd9:    e = mk(COEF_B, 1'b0, 4'd9);
            7'd10:   e = mk(COEF_C, 1'b1, 4'd10);
            7'd11:   e = mk(COEF_A, 1'b0, 4'd9);
            7'd12:   e = mk(COEF_C, 1'b0, 4'd9);
            7'd13:   e = mk(COEF_C, 1'b1, 4'd11);
            7'd14:   e = mk(COEF_A, 1'b0, 4'd8);
            7'd15:   e = mk(COEF_B, 1'b0, 4'd9);
            7'd16:   e = mk(COEF_D, 1'b0, 4'd9);
            7'd17:   e = mk(COEF_E, 1'b0, 4'd10);
            7'd18:   e = mk(COEF_F, 1'b0, 4'd9);
            7'd19:   e = mk(COEF_G, 1'b0, 4'd9);
            default: e = ENTRY_SILENT;
        endcase
        return e;
    endfunction

    // Clamp to the signed range of the filter history.
    function automatic logic signed [Y_W-1:0] sat_y(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = (ACC_W'(1) <<< (Y_W-1)) - ACC_W'(1);
        lo = -(ACC_W'(1) <<< (Y_W-1));
        if (v > hi) begin
            return hi[Y_W-1:0];
        end else if (v < lo) begin
            return lo[Y_W-1:0];
        end
        return v[Y_W-1:0];
    endfunction

endpackage

/* hdl/lfsr_noise_resonator.sv */
// Top level: LFSR noise source feeding a two-pole resonator, int8 output.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+--------------------------------
//  in      | into blk  | i_in_valid / o_in_ready   | i_kind, i_noise_index
//  out     | from blk  | o_out_valid / i_out_ready | o_out_sample
//
//  One beat per cycle while o_in_ready is high: the whole filter step (one 16x48
//  product split into two partial products, the damping shift-adds, saturation,
//  output scaling) sits between the state registers and the output register.
//  A restart beat gives no output beat; a sample beat gives exactly one.
//  o_in_ready drops only while the output register holds a beat that is not
//  being taken this cycle. Synchronous active-low reset: silent, LFSR at seed.
module lfsr_noise_resonator #(
    parameter int FRAC_BITS = 16        // fraction bits of the filter state, 8..24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_kind,
    input  logic [lnr_pkg::IDX_W-1:0]      i_noise_index,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [lnr_pkg::SAMPLE_W-1:0] o_out_sample
);
    import lnr_pkg::*;

    // Filter state
    logic [15:0]                 r_lfsr;
    logic [NOISE_W-1:0]          r_prev_noise;
    logic signed [Y_W-1:0]       r_y1;
    logic signed [Y_W-1:0]       r_y2;
    logic signed [COEF_W-1:0]    r_coef;
    logic                        r_light;
    logic [SHIFT_W-1:0]          r_shift;
    logic                        r_silent;

    // Output register
    logic                        r_out_valid;
    logic signed [SAMPLE_W-1:0]  r_out_sample;

    logic                        accept;
    logic                        is_sample;
    t_entry                      n_entry;

    // LFSR step
    logic                        fb;
    logic [15:0]                 n_lfsr;
    logic [NOISE_W-1:0]          x_new;

    // Filter datapath
    logic signed [ACC_W-1:0]     two_y1;
    logic signed [ACC_W-1:0]     xprev_sc;
    logic signed [Y_W-1:0]       temp;
    logic signed [39:0]          p_hi;
    logic signed [40:0]          p_lo;
    logic signed [63:0]          prod_full;
    logic signed [63:0]          prod_sh;
    logic signed [ACC_W-1:0]     y2e;
    logic signed [ACC_W-1:0]     damp;
    logic signed [ACC_W-1:0]     x_sc;
    logic signed [ACC_W-1:0]     sum;
    logic signed [Y_W-1:0]       n_y;

    // Output scaling
    logic [5:0]                  sh;
    logic                        y_neg;
    logic [Y_W-1:0]              mag;
    logic [Y_W-1:0]              mag_sh;
    logic signed [SAMPLE_W-1:0]  n_sample;

    assign o_in_ready   = !r_out_valid || i_out_ready;
    assign accept       = i_in_valid && o_in_ready;
    assign is_sample    = (i_kind == KIND_SAMPLE);
    assign n_entry      = entry_lookup(i_noise_index);
    assign o_out_valid  = r_out_valid;
    assign o_out_sample = r_out_sample;

    // Feedback is the parity of taps 0, 2, 3 and 5.
    assign fb     = ^(r_lfsr & LFSR_TAPS);
    assign n_lfsr = {1'b0, r_lfsr[15] | fb, r_lfsr[14:1]};
    assign x_new  = n_lfsr[14:2];

    always_comb begin
        // t = 2*y1 - xprev, saturated to the history width
        two_y1   = ACC_W'(r_y1) <<< 1;
        xprev_sc = $signed(ACC_W'(r_prev_noise) << FRAC_BITS);
        temp     = sat_y(two_y1 - xprev_sc);

        // c*t as two partial products, then floor shift by the Q15 point
        p_hi      = r_coef * $signed(temp[Y_W-1:24]);
        p_lo      = r_coef * $signed({1'b0, temp[23:0]});
        prod_full = (64'(p_hi) <<< 24) + 64'(p_lo);
        prod_sh   = prod_full >>> COEF_FRAC;

        // damping: 5/8 or 25/32 of y2, floor
        y2e = ACC_W'(r_y2);
        if (r_light) begin
            damp = ((y2e <<< 2) + y2e) >>> 3;
        end else begin
            damp = ((y2e <<< 4) + (y2e <<< 3) + y2e) >>> 5;
        end

        x_sc = $signed(ACC_W'(x_new) << FRAC_BITS);
        sum  = $signed(prod_sh[ACC_W-1:0]) + x_sc - damp;
        n_y  = sat_y(sum);

        // y / 2^(shift+frac), truncated toward zero, clamped to int8
        sh     = 6'(r_shift) + 6'(FRAC_BITS);
        y_neg  = n_y[Y_W-1];
        mag    = y_neg ? Y_W'(-n_y) : Y_W'(n_y);
        mag_sh = mag >> sh;
        if (y_neg) begin
            n_sample = (|mag_sh[Y_W-1:7]) ? -8'sd128 : $signed(-mag_sh[7:0]);
        end else begin
            n_sample = (|mag_sh[Y_W-1:7]) ? 8'sd127 : $signed(mag_sh[7:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr       <= LFSR_SEED;
            r_prev_noise <= '0;
            r_y1         <= '0;
            r_y2         <= '0;
            r_coef       <= '0;
            r_light      <= 1'b0;
            r_shift      <= SHIFT_DEFAULT;
            r_silent     <= 1'b1;
            r_out_valid  <= 1'b0;
        end else begin
            // a new sample beat refills the slot, else a taken beat empties it
            if (accept && is_sample) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (accept) begin
                if (!is_sample) begin
                    // restart: new entry, fresh noise and filter history
                    r_silent     <= !n_entry.valid;
                    r_coef       <= $signed(n_entry.coef);
                    r_light      <= n_entry.light;
                    r_shift      <= n_entry.shift;
                    r_lfsr       <= LFSR_SEED;
                    r_prev_noise <= '0;
                    r_y1         <= '0;
                    r_y2         <= '0;
                end else if (!r_silent) begin
                    r_lfsr       <= n_lfsr;
                    r_prev_noise <= x_new;
                    r_y2         <= r_y1;
                    r_y1         <= n_y;
                end
            end
        end
    end

    // payload register, no reset
    always_ff @(posedge i_clk) begin
        if (accept && is_sample) begin
            r_out_sample <= r_silent ? '0 : n_sample;
        end
    end

endmodule
